/* design/ppwfp_pkg.sv */
package ppwfp_pkg;

   localparam int DATA_W     = 32;
   localparam int W_FRAC     = 16;
   localparam int W_W        = W_FRAC + 1;
   localparam int QUOT_W     = W_FRAC;
   localparam int CSR_ADDR_W = 4;

   localparam logic [W_W-1:0]    W_ONE   = W_W'(1) << W_FRAC;
   localparam logic [DATA_W-1:0] SAT_POS = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic {
      ACT_WRITE,
      ACT_EVAL
   } action_type;

   typedef enum logic [1:0] {
      CSR_WMIN,
      CSR_WMAX,
      CSR_TERMS
   } csr_index_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] numer;
      logic [DATA_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic clear;
      logic mult;
      logic accum;
   } mac_ctrl_type;

endpackage

/* design/ppwfp_if.sv */
interface ppwfp_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] wavelength;
   logic [6:0]  col;
   logic [6:0]  row;
   logic [1:0]  plane;
   logic [31:0] coeff_value;

   modport source (output valid, action, wavelength, col, row, plane, coeff_value,
                   input ready);
   modport sink   (input valid, action, wavelength, col, row, plane, coeff_value,
                   output ready);
endinterface

interface ppwfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] flat_value;
   logic        clamped;

   modport source (output valid, flat_value, clamped, input ready);
   modport sink   (input valid, flat_value, clamped, output ready);
endinterface

/* design/ppwfp_ram.sv */
module ppwfp_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/ppwfp_div.sv */
module ppwfp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  ppwfp_pkg::div_req_type div_req,
   output ppwfp_pkg::div_rsp_type div_rsp
);
   import ppwfp_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] denom_ff, denom_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;

   // restoring division, one quotient bit a cycle; remainder always below divisor
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quot_in  = quot_ff;
      shifted  = {rem_ff, 1'b0};
      trial    = shifted - {1'b0, denom_ff};
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = div_req.numer;
         denom_in = div_req.denom;
         quot_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, denom_ff}) begin
            rem_in  = trial[DATA_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DATA_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quot_ff  <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

/* design/ppwfp_mac.sv */
module ppwfp_mac #(
   parameter int ACC_W = 35
) (
   input  logic                    clock,
   input  ppwfp_pkg::mac_ctrl_type mac_ctrl,
   input  logic [ppwfp_pkg::W_W-1:0] weight,
   input  logic signed [31:0]      coeff,
   output logic signed [ACC_W-1:0] acc
);
   import ppwfp_pkg::*;

   localparam int PROD_W = ACC_W + W_W + 1;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [W_W:0]      weight_s;

   assign weight_s = $signed({1'b0, weight});

   // horner step: acc = floor(acc * w / 2^16) + c, split into a registered multiply and an accumulate
   always_comb begin
      acc_in  = acc_ff;
      prod_in = PROD_W'(acc_ff) * PROD_W'(weight_s);
      if (mac_ctrl.clear) begin
         acc_in = '0;
      end else if (mac_ctrl.accum) begin
         acc_in = $signed(prod_ff[ACC_W+W_FRAC-1:W_FRAC])
                + $signed({{(ACC_W-DATA_W){coeff[DATA_W-1]}}, coeff});
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (mac_ctrl.mult) begin
         prod_ff <= prod_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* design/per_pixel_wavelength_flat_poly.sv */
// Per-pixel polynomial flat field. A write word stores one Q8.24 coefficient of the cube
// at (plane, row, col); an evaluate word brings a Q24.8 wavelength and a pixel, and gets
// back one result word: sum c_i * w^i over min(term_count, TERMS) planes by Horner's rule,
// saturated to 32 bits, with w = (|wavelength| - wmin) / (wmax - wmin) in Q1.16 (floor),
// forced to 0 below wmin and to 1.0 above wmax (clamped set in both cases). The block
// takes one word at a time. When w needs a division, the sequencer waits on the bit-serial
// divider for its 16-bit quotient, and each plane costs one coefficient memory read plus
// one pass through the shared multiply-add; when no plane is in use those steps are
// skipped. The coefficient memory is one single-port RAM of TERMS*HEIGHT*WIDTH words
// with no clearing; entries must be written before they are read. A finished result
// sits in the output register while the next word is accepted.
module per_pixel_wavelength_flat_poly #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 128,
   parameter int TERMS  = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   ppwfp_req_if.sink                          req_if,
   ppwfp_rsp_if.source                        rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ppwfp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ppwfp_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [ppwfp_pkg::DATA_W-1:0]       csr_prdata,
   output logic                               csr_pready
);
   import ppwfp_pkg::*;

   localparam int PLANE_SIZE = HEIGHT * WIDTH;
   localparam int CUBE_SIZE  = TERMS * PLANE_SIZE;
   localparam int AW         = (CUBE_SIZE > 1) ? $clog2(CUBE_SIZE) : 1;
   localparam int NW         = $clog2(TERMS + 1);
   localparam int ACC_W      = DATA_W + $clog2(TERMS) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_PREP,
      ST_DECIDE,
      ST_DIVIDE,
      ST_ISSUE,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   // configuration registers
   logic signed [DATA_W-1:0] wmin_ff;
   logic signed [DATA_W-1:0] wmax_ff;
   logic [2:0]               terms_ff;
   logic                     csr_we;

   // sequencer and result registers
   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] flat_ff, flat_in;
   logic        rsp_clamp_ff, rsp_clamp_in;

   // captured word
   logic signed [DATA_W-1:0] lam_ff, lam_in;
   logic [6:0]               col_ff, col_in;
   logic [6:0]               row_ff, row_in;
   logic [1:0]               plane_ff, plane_in;
   logic [DATA_W-1:0]        coeff_ff, coeff_in;

   // normalization
   logic                     above_ff, above_in;
   logic                     below_ff, below_in;
   logic                     clamp_ff, clamp_in;
   logic signed [DATA_W:0]   range_ff, range_in;
   logic signed [DATA_W+1:0] num_ff, num_in;
   logic [DATA_W:0]          mag;
   logic [W_W-1:0]           w_ff, w_in;
   logic [NW-1:0]            k_ff, k_in;

   logic                     on_cube;
   logic                     plane_ok;
   logic [31:0]              n_full;
   logic [NW-1:0]            n_eff;
   logic [31:0]              sel_plane;
   logic [31:0]              addr_full;
   logic [AW-1:0]            ram_addr;
   logic                     ram_we;
   logic [DATA_W-1:0]        ram_rdata;
   logic signed [ACC_W-1:0]  acc;
   logic [ACC_W-DATA_W:0]    acc_hi;
   div_req_type              div_req;
   div_rsp_type              div_rsp;
   mac_ctrl_type             mac_ctrl;

   // ---------------------------------------------------------------------------------------
   // register port: writes land on the access cycle, reads are a plain mux
   // ---------------------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wmin_ff  <= '0;
         wmax_ff  <= '0;
         terms_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_paddr[CSR_ADDR_W-1:2])
            CSR_WMIN:  wmin_ff  <= csr_pwdata;
            CSR_WMAX:  wmax_ff  <= csr_pwdata;
            CSR_TERMS: terms_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1:2])
         CSR_WMIN:  csr_prdata = wmin_ff;
         CSR_WMAX:  csr_prdata = wmax_ff;
         CSR_TERMS: csr_prdata = {29'd0, terms_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // cube addressing: (plane * HEIGHT + row) * WIDTH + col
   // ---------------------------------------------------------------------------------------
   assign on_cube  = (32'(col_ff) < WIDTH) && (32'(row_ff) < HEIGHT);
   assign plane_ok = 32'(plane_ff) < TERMS;

   // planes in use, capped at the cube depth; a pixel off the cube reads as all zero
   assign n_full = (32'(terms_ff) > TERMS) ? 32'(TERMS) : 32'(terms_ff);
   assign n_eff  = on_cube ? n_full[NW-1:0] : '0;

   // horner runs from the highest plane down, so the read plane is k - 1
   assign sel_plane = (state_ff == ST_ISSUE) ? 32'(k_ff - 1'b1) : 32'(plane_ff);
   assign addr_full = sel_plane * 32'(PLANE_SIZE) + 32'(row_ff) * 32'(WIDTH) + 32'(col_ff);
   assign ram_addr  = addr_full[AW-1:0];

   // magnitude of the wavelength, 33 bits so that the most negative value fits
   assign mag = lam_ff[DATA_W-1] ? ((DATA_W+1)'(0) - {lam_ff[DATA_W-1], lam_ff})
                                 : {1'b0, lam_ff};

   // saturation check on the accumulator's upper bits
   assign acc_hi = acc[ACC_W-1:DATA_W-1];

   // ---------------------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      flat_in      = flat_ff;
      rsp_clamp_in = rsp_clamp_ff;
      lam_in       = lam_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      plane_in     = plane_ff;
      coeff_in     = coeff_ff;
      above_in     = above_ff;
      below_in     = below_ff;
      clamp_in     = clamp_ff;
      range_in     = range_ff;
      num_in       = num_ff;
      w_in         = w_ff;
      k_in         = k_ff;
      ram_we       = 1'b0;
      div_req      = '0;
      mac_ctrl     = '0;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               lam_in   = req_if.wavelength;
               col_in   = req_if.col;
               row_in   = req_if.row;
               plane_in = req_if.plane;
               coeff_in = req_if.coeff_value;
               state_in = (req_if.action == ACT_WRITE) ? ST_WRITE : ST_PREP;
            end
         end
         ST_WRITE: begin
            // writes off the cube or past the last plane are dropped
            ram_we   = on_cube && plane_ok;
            state_in = ST_IDLE;
         end
         ST_PREP: begin
            above_in = lam_ff > wmax_ff;
            below_in = lam_ff < wmin_ff;
            clamp_in = (lam_ff > wmax_ff) || (lam_ff < wmin_ff);
            range_in = $signed({wmax_ff[DATA_W-1], wmax_ff})
                     - $signed({wmin_ff[DATA_W-1], wmin_ff});
            num_in   = $signed({1'b0, mag}) - $signed({{2{wmin_ff[DATA_W-1]}}, wmin_ff});
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            mac_ctrl.clear = 1'b1;
            k_in           = n_eff;
            state_in       = ST_ISSUE;
            if (n_eff == '0) begin
               state_in = ST_FINISH;
            end else if (above_ff) begin
               // above range wins over below range
               w_in = W_ONE;
            end else if (below_ff) begin
               w_in = '0;
            end else if ((range_ff == '0) || (num_ff <= 0)) begin
               // empty range or magnitude at or under the lower bound
               w_in = '0;
            end else if (num_ff >= $signed({range_ff[DATA_W], range_ff})) begin
               w_in = W_ONE;
            end else begin
               // 0 < num < range, both fit 32 bits unsigned
               div_req.start = 1'b1;
               div_req.numer = num_ff[DATA_W-1:0];
               div_req.denom = range_ff[DATA_W-1:0];
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               w_in     = {1'b0, div_rsp.quot};
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            // coefficient read and acc * w run in the same cycle
            mac_ctrl.mult = 1'b1;
            state_in      = ST_ACCUM;
         end
         ST_ACCUM: begin
            mac_ctrl.accum = 1'b1;
            k_in           = k_ff - 1'b1;
            state_in       = (k_ff == NW'(1)) ? ST_FINISH : ST_ISSUE;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_clamp_in = clamp_ff;
               if ((acc_hi == '0) || (acc_hi == '1)) begin
                  flat_in = acc[DATA_W-1:0];
               end else begin
                  flat_in = acc[ACC_W-1] ? SAT_NEG : SAT_POS;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      flat_ff      <= flat_in;
      rsp_clamp_ff <= rsp_clamp_in;
      lam_ff       <= lam_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      plane_ff     <= plane_in;
      coeff_ff     <= coeff_in;
      above_ff     <= above_in;
      below_ff     <= below_in;
      clamp_ff     <= clamp_in;
      range_ff     <= range_in;
      num_ff       <= num_in;
      w_ff         <= w_in;
      k_ff         <= k_in;
   end

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.flat_value = flat_ff;
   assign rsp_if.clamped    = rsp_clamp_ff;

   // ---------------------------------------------------------------------------------------
   // shared units
   // ---------------------------------------------------------------------------------------
   ppwfp_ram #(
      .DATA_W (DATA_W),
      .DEPTH  (CUBE_SIZE),
      .ADDR_W (AW)
   ) u_coeff_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (coeff_ff),
      .rdata (ram_rdata)
   );

   ppwfp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ppwfp_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock    (clock),
      .mac_ctrl (mac_ctrl),
      .weight   (w_ff),
      .coeff    ($signed(ram_rdata)),
      .acc      (acc)
   );

   // ---------------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------------
   a_write_only_in_write_state : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_WRITE))
      else $error("coefficient memory written outside a write word");

   a_div_done_while_waiting : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished while the sequencer was not waiting for it");

   a_weight_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (w_ff <= W_ONE))
      else $error("normalized wavelength above 1.0 in a horner step");

   a_finish_loads_result : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready))
      |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished evaluate did not reach the output register");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ppwfp_pkg::*;

   localparam int     PIX_COUNT   = 128 * 128;
   localparam int     PLANES      = 4;
   localparam int     SETTLE_CYC  = 40;    // wait after the last result so a trailing write word finishes
   localparam int     STALL_LIMIT = 4000;  // cycles without any handshake before giving up
   localparam int     HOLD_CYC    = 500;   // long receiver hold-off to back up the block
   localparam int     PHASES      = 12;
   localparam int     PHASE_ITEMS = 100;
   localparam int     POOL_SIZE   = 16;
   localparam longint W_UNIT      = 65536; // 1.0 in the Q1.16 weight
   localparam longint SAT_HI      = 64'sh0000_0000_7fff_ffff;
   localparam longint SAT_LO      = 64'shffff_ffff_8000_0000;

   // one expected result word
   typedef struct packed {
      logic [31:0] flat;
      logic        clamp;
   } flat_result_type;

   // one row of the directed table: either a register write or a request word
   typedef struct {
      bit              is_csr;
      csr_index_type   csr_sel;
      logic [31:0]     csr_val;
      action_type      act;
      logic [31:0]     lam;
      logic [6:0]      col;
      logic [6:0]      row;
      logic [1:0]      plane;
      logic [31:0]     coeff;
      bit              typed;   // expected result typed into the table
      flat_result_type want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0]     csr_pwdata;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   ppwfp_req_if req_bus ();
   ppwfp_rsp_if rsp_bus ();

   per_pixel_wavelength_flat_poly uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow copy of the coefficient cube and the registers
   logic [31:0] coeff_shadow [0:PLANES*PIX_COUNT-1];
   bit   [3:0]  written_planes [0:PIX_COUNT-1];
   logic [31:0] wmin_shadow  = '0;
   logic [31:0] wmax_shadow  = '0;
   logic [2:0]  terms_shadow = '0;

   flat_result_type pending_flats[$];
   stim_row_type    dir_tab[$];
   int              pool_pix [POOL_SIZE];
   int              mismatch_count = 0;
   int              results_seen   = 0;
   bit              send_gaps_on   = 1'b1;
   bit              take_gaps_on   = 1'b1;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   // flat value for one evaluate word against the current shadow state
   function automatic flat_result_type predict_flat(logic [31:0] lam, logic [6:0] col,
                                                    logic [6:0] row);
      longint          l, lo, hi, rng, mag, num, w, acc, c;
      int              n, k, pix;
      bit              clamp;
      flat_result_type res;
      l     = $signed(lam);
      lo    = $signed(wmin_shadow);
      hi    = $signed(wmax_shadow);
      clamp = (l < lo) || (l > hi);
      // above range wins when both hold (max below min)
      if (l > hi) begin
         w = W_UNIT;
      end else if (l < lo) begin
         w = 0;
      end else begin
         rng = hi - lo;
         mag = (l < 0) ? -l : l;
         num = mag - lo;
         if (rng <= 0 || num <= 0) begin
            w = 0;            // zero range or magnitude at/below the floor
         end else if (num >= rng) begin
            w = W_UNIT;       // negative wavelength can reflect past the top
         end else begin
            w = (num * W_UNIT) / rng;
         end
         if (w > W_UNIT) w = W_UNIT;
      end
      n   = (terms_shadow > 3'd4) ? PLANES : int'(terms_shadow);
      pix = int'(row) * 128 + int'(col);
      acc = 0;
      // horner from the top plane down, floor on every step
      for (k = n; k > 0; k--) begin
         c   = $signed(coeff_shadow[(k - 1) * PIX_COUNT + pix]);
         acc = ((acc * w) >>> 16) + c;
      end
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      res.flat  = acc[31:0];
      res.clamp = clamp;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // table rows and random picks
   // ---------------------------------------------------------------

   function automatic stim_row_type blank_row();
      stim_row_type r;
      r.is_csr  = 1'b0;
      r.csr_sel = CSR_WMIN;
      r.csr_val = '0;
      r.act     = ACT_WRITE;
      r.lam     = $urandom;
      r.col     = '0;
      r.row     = '0;
      r.plane   = 2'($urandom_range(0, 3));
      r.coeff   = $urandom;
      r.typed   = 1'b0;
      r.want    = '0;
      return r;
   endfunction

   function automatic stim_row_type csr_row(csr_index_type sel, logic [31:0] val);
      stim_row_type r;
      r         = blank_row();
      r.is_csr  = 1'b1;
      r.csr_sel = sel;
      r.csr_val = val;
      return r;
   endfunction

   function automatic stim_row_type write_row(logic [6:0] col, logic [6:0] row,
                                              logic [1:0] plane, logic [31:0] coeff);
      stim_row_type r;
      r       = blank_row();
      r.col   = col;
      r.row   = row;
      r.plane = plane;
      r.coeff = coeff;
      return r;
   endfunction

   function automatic stim_row_type eval_row(logic [31:0] lam, logic [6:0] col,
                                             logic [6:0] row);
      stim_row_type r;
      r     = blank_row();
      r.act = ACT_EVAL;
      r.lam = lam;
      r.col = col;
      r.row = row;
      return r;
   endfunction

   function automatic stim_row_type eval_known(logic [31:0] lam, logic [6:0] col,
                                               logic [6:0] row, logic [31:0] flat,
                                               logic clamp);
      stim_row_type r;
      r            = eval_row(lam, col, row);
      r.typed      = 1'b1;
      r.want.flat  = flat;
      r.want.clamp = clamp;
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_coeff();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 32'h03ff_ffff) - 32'h0200_0000;  // about +-2.0
      if (r < 85) return $urandom;
      if (r < 92) return 32'h7fff_ffff;
      return 32'h8000_0000;
   endfunction

   // wavelength aimed at the current range: within, mirrored, edges, outside, anywhere
   function automatic logic [31:0] pick_lambda();
      longint      lo, hi, span, off;
      int          r;
      logic [31:0] lam;
      lo = $signed(wmin_shadow);
      hi = $signed(wmax_shadow);
      r  = $urandom_range(0, 99);
      if (r < 55 && lo <= hi) begin
         span = hi - lo + 1;
         off  = {$urandom, $urandom} % span;
         lam  = 32'(lo + off);
         if (r >= 45) lam = -lam;   // negative sample, magnitude used
      end else if (r < 65) begin
         case ($urandom_range(0, 3))
            0: lam = wmin_shadow;
            1: lam = wmax_shadow;
            2: lam = wmin_shadow - 1;
            default: lam = wmax_shadow + 1;
         endcase
      end else if (r < 80) begin
         lam = wmin_shadow - $urandom_range(1, 1000);
      end else if (r < 90) begin
         lam = wmax_shadow + $urandom_range(1, 1000);
      end else begin
         lam = $urandom;
      end
      return lam;
   endfunction

   // ---------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("mismatch at %0t: %s", $time, what);
   endtask

   // register write: setup cycle then access cycle
   task automatic write_csr(input csr_index_type sel, input logic [31:0] val);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'(int'(sel) * 4);
      csr_pwdata  = val;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (sel)
         CSR_WMIN:  wmin_shadow  = val;
         CSR_WMAX:  wmax_shadow  = val;
         CSR_TERMS: terms_shadow = val[2:0];
         default: ;
      endcase
   endtask

   // drop valid, wait for every result, then let a trailing write word finish
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_flats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // offer one request word; valid stays up into the next word when there is no gap
   task automatic send_word(input stim_row_type r);
      int gap;
      int pix;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid       = 1'b1;
      req_bus.action      = r.act;
      req_bus.wavelength  = r.lam;
      req_bus.col         = r.col;
      req_bus.row         = r.row;
      req_bus.plane       = r.plane;
      req_bus.coeff_value = r.coeff;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      // word taken at this edge
      pix = int'(r.row) * 128 + int'(r.col);
      if (r.act == ACT_WRITE) begin
         coeff_shadow[int'(r.plane) * PIX_COUNT + pix] = r.coeff;
         written_planes[pix] |= 4'(1 << r.plane);
      end else begin
         pending_flats.push_back(r.typed ? r.want : predict_flat(r.lam, r.col, r.row));
      end
   endtask

   // new register settings for one random phase; the first phases cover each shape
   task automatic configure_phase(input int phase);
      logic [31:0] lo, hi, t;
      logic [2:0]  tc;
      int          mode;
      mode = (phase < 6) ? phase : $urandom_range(0, 5);
      case (mode)
         0: begin   // moderate range around zero
            lo = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            hi = lo + $urandom_range(1, 32'h0010_0000);
         end
         1: begin   // anywhere, ordered
            lo = $urandom;
            hi = $urandom;
            if ($signed(lo) > $signed(hi)) begin
               t  = lo;
               lo = hi;
               hi = t;
            end
         end
         2: begin   // full signed span
            lo = 32'h8000_0000;
            hi = 32'h7fff_ffff;
         end
         3: begin   // zero range
            lo = $urandom_range(0, 32'h0000_4000);
            hi = lo;
         end
         4: begin   // maximum below minimum
            hi = $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
            lo = hi + $urandom_range(1, 32'h0000_1000);
         end
         default: begin   // tiny positive range, truncation heavy
            lo = $urandom_range(0, 32'h0000_1000);
            hi = lo + $urandom_range(1, 32'h0000_0100);
         end
      endcase
      if (phase == 1) tc = 3'd0;
      else if (phase == 2) tc = 3'd7;
      else if ($urandom_range(0, 9) < 4) tc = 3'd4;
      else tc = 3'($urandom_range(0, 7));
      t      = $urandom;
      t[2:0] = tc;   // upper bits are don't care
      write_csr(CSR_WMIN, lo);
      write_csr(CSR_WMAX, hi);
      write_csr(CSR_TERMS, t);
      // some phases run without any idling on one or both sides
      send_gaps_on = ($urandom_range(0, 3) != 0);
      take_gaps_on = ($urandom_range(0, 3) != 0);
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   initial begin : stimulus
      int         r, pix, sent, n, p, pl;
      logic [3:0] need;

      reset               = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_WRITE;
      req_bus.wavelength  = '0;
      req_bus.col         = '0;
      req_bus.row         = '0;
      req_bus.plane       = '0;
      req_bus.coeff_value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset: zero range and no planes in use
      dir_tab.push_back(eval_known(32'h0000_0000, 7'd0, 7'd0, 32'h0, 1'b0));
      dir_tab.push_back(eval_known(32'h8000_0000, 7'd127, 7'd127, 32'h0, 1'b1));
      dir_tab.push_back(eval_known(32'h7fff_ffff, 7'd0, 7'd127, 32'h0, 1'b1));
      // corner pixel: 1.0, 1.0, -1.0, 0.5
      dir_tab.push_back(write_row(7'd0, 7'd0, 2'd0, 32'h0100_0000));
      dir_tab.push_back(write_row(7'd0, 7'd0, 2'd1, 32'h0100_0000));
      dir_tab.push_back(write_row(7'd0, 7'd0, 2'd2, 32'hff00_0000));
      dir_tab.push_back(write_row(7'd0, 7'd0, 2'd3, 32'h0080_0000));
      // opposite corner at the positive limit on every plane
      for (pl = 0; pl < PLANES; pl++)
         dir_tab.push_back(write_row(7'd127, 7'd127, 2'(pl), 32'h7fff_ffff));
      // range 0 .. 4.0, constant term only
      dir_tab.push_back(csr_row(CSR_WMIN, 32'h0000_0000));
      dir_tab.push_back(csr_row(CSR_WMAX, 32'h0000_0400));
      dir_tab.push_back(csr_row(CSR_TERMS, 32'd1));
      dir_tab.push_back(eval_known(32'h0000_0200, 7'd0, 7'd0, 32'h0100_0000, 1'b0));
      dir_tab.push_back(eval_known(32'hffff_fe00, 7'd0, 7'd0, 32'h0100_0000, 1'b1));
      // term count above the plane count
      dir_tab.push_back(csr_row(CSR_TERMS, 32'd7));
      dir_tab.push_back(eval_row(32'h0000_0200, 7'd0, 7'd0));
      dir_tab.push_back(eval_known(32'h0000_0400, 7'd0, 7'd0, 32'h0180_0000, 1'b0));
      dir_tab.push_back(eval_known(32'h0000_0401, 7'd0, 7'd0, 32'h0180_0000, 1'b1));
      dir_tab.push_back(eval_known(32'h7fff_ffff, 7'd127, 7'd127, SAT_POS, 1'b1));
      // negative limit on every plane saturates low
      for (pl = 0; pl < PLANES; pl++)
         dir_tab.push_back(write_row(7'd127, 7'd127, 2'(pl), 32'h8000_0000));
      dir_tab.push_back(eval_known(32'h0000_0401, 7'd127, 7'd127, SAT_NEG, 1'b1));
      // full signed span
      dir_tab.push_back(csr_row(CSR_WMIN, 32'h8000_0000));
      dir_tab.push_back(csr_row(CSR_WMAX, 32'h7fff_ffff));
      dir_tab.push_back(eval_row(32'h8000_0000, 7'd0, 7'd0));
      // zero range, two planes
      dir_tab.push_back(csr_row(CSR_WMIN, 32'h0000_0100));
      dir_tab.push_back(csr_row(CSR_WMAX, 32'h0000_0100));
      dir_tab.push_back(csr_row(CSR_TERMS, 32'd2));
      dir_tab.push_back(eval_known(32'h0000_0100, 7'd0, 7'd0, 32'h0100_0000, 1'b0));
      dir_tab.push_back(eval_known(32'hffff_ff00, 7'd0, 7'd0, 32'h0100_0000, 1'b1));
      // maximum below minimum: above wins, w is 1.0
      dir_tab.push_back(csr_row(CSR_WMIN, 32'h0000_0200));
      dir_tab.push_back(eval_known(32'h0000_0180, 7'd0, 7'd0, 32'h0200_0000, 1'b1));

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) begin
            settle_block();
            write_csr(dir_tab[i].csr_sel, dir_tab[i].csr_val);
         end else begin
            send_word(dir_tab[i]);
         end
      end

      // pool of fully loaded pixels, corners first
      pool_pix[0] = 0;
      pool_pix[1] = PIX_COUNT - 1;
      pool_pix[2] = 127;
      pool_pix[3] = 127 * 128;
      for (p = 4; p < POOL_SIZE; p++) pool_pix[p] = $urandom_range(0, PIX_COUNT - 1);
      for (p = 0; p < POOL_SIZE; p++)
         for (pl = 0; pl < PLANES; pl++)
            send_word(write_row(7'(pool_pix[p] % 128), 7'(pool_pix[p] / 128), 2'(pl),
                                pick_coeff()));

      for (int phase = 0; phase < PHASES; phase++) begin
         settle_block();
         configure_phase(phase);
         n    = (terms_shadow > 3'd4) ? PLANES : int'(terms_shadow);
         need = 4'((1 << n) - 1);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               // load a fresh pixel on every plane, then evaluate it
               pix = $urandom_range(0, PIX_COUNT - 1);
               for (pl = 0; pl < PLANES; pl++)
                  send_word(write_row(7'(pix % 128), 7'(pix / 128), 2'(pl), pick_coeff()));
               send_word(eval_row(pick_lambda(), 7'(pix % 128), 7'(pix / 128)));
               sent += 5;
            end else if (r < 40) begin
               // single coefficient update, pool or anywhere
               if ($urandom_range(0, 1) != 0) pix = pool_pix[$urandom_range(0, POOL_SIZE - 1)];
               else pix = $urandom_range(0, PIX_COUNT - 1);
               send_word(write_row(7'(pix % 128), 7'(pix / 128), 2'($urandom_range(0, 3)),
                                   pick_coeff()));
               sent++;
            end else begin
               // evaluate only where every plane in use has been written
               pix = $urandom_range(0, PIX_COUNT - 1);
               if ((written_planes[pix] & need) != need)
                  pix = pool_pix[$urandom_range(0, POOL_SIZE - 1)];
               send_word(eval_row(pick_lambda(), 7'(pix % 128), 7'(pix / 128)));
               sent++;
            end
         end
      end

      settle_block();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // result side: ready with random gaps and two long hold-offs
   // ---------------------------------------------------------------

   initial begin : result_taker
      int gap_left, hold_left, holds_done;
      gap_left      = 0;
      hold_left     = 0;
      holds_done    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         // hold off long enough that the block backs up and stalls its input
         if (holds_done < 2 && results_seen >= 150 + 350 * holds_done) begin
            hold_left = HOLD_CYC;
            holds_done++;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_bus.ready = 1'b0;
            gap_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            gap_left      = take_gaps_on ? pick_gap() : 0;
         end
      end
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin : check_results
      flat_result_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (pending_flats.size() == 0) begin
            report_mismatch($sformatf("result word with nothing pending: flat %h clamped %b",
                                      rsp_bus.flat_value, rsp_bus.clamped));
         end else begin
            want = pending_flats.pop_front();
            if (rsp_bus.flat_value !== want.flat)
               report_mismatch($sformatf("flat_value %h, want %h", rsp_bus.flat_value,
                                         want.flat));
            if (rsp_bus.clamped !== want.clamp)
               report_mismatch($sformatf("clamped %b, want %b", rsp_bus.clamped, want.clamp));
         end
      end
   end

   // watchdog: any handshake on any port restarts the count
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset === 1'b1 ||
             (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_psel === 1'b1 && csr_penable === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

endmodule
